[rtl/axis_rotation_pos_vel_macros.svh]
// Assertion macros used by the arpv_rot_stage module.
// Every macro samples on clock and is disabled while reset is high.
`ifndef AXIS_ROTATION_POS_VEL_MACROS_SVH
`define AXIS_ROTATION_POS_VEL_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ARPV_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ARPV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/arpv_pkg.sv]
// Shared types and constants for the three-axis position/velocity rotator.
// No dependencies; used by the rotation stage, the top level and the testbench.
package arpv_pkg;

   localparam int NUM_LANES       = 6;
   localparam int LANE_BITS       = 3;
   localparam int LANES_PER_GROUP = 3;
   localparam int CSR_INDEX_WIDTH = 3;

   // Coefficient register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COS_X = 3'd0,
      CSR_SIN_X = 3'd1,
      CSR_COS_Y = 3'd2,
      CSR_SIN_Y = 3'd3,
      CSR_COS_Z = 3'd4,
      CSR_SIN_Z = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   // Lane order inside a group: x, y, z. Position is group 0, velocity group 1.
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   // First coordinate of the rotated plane
   function automatic int axis_p_lane(input axis_type axis);
      int lane;
      case (axis)
         AXIS_X:  lane = LANE_Y;
         AXIS_Y:  lane = LANE_X;
         AXIS_Z:  lane = LANE_X;
         default: lane = LANE_X;
      endcase
      return lane;
   endfunction

   // Second coordinate of the rotated plane
   function automatic int axis_q_lane(input axis_type axis);
      int lane;
      case (axis)
         AXIS_X:  lane = LANE_Z;
         AXIS_Y:  lane = LANE_Z;
         AXIS_Z:  lane = LANE_Y;
         default: lane = LANE_Y;
      endcase
      return lane;
   endfunction

   // The y rotation runs (x, z) with the sine negated
   function automatic logic axis_neg_sin(input axis_type axis);
      return axis == AXIS_Y;
   endfunction

endpackage

[rtl/arpv_stream_if.sv]
// Valid/ready stream interfaces for body beats in and rotated beats out.
// Standalone; the coordinate width follows COORD_WIDTH.
interface arpv_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [COORD_WIDTH-1:0] vel_x;
   logic signed [COORD_WIDTH-1:0] vel_y;
   logic signed [COORD_WIDTH-1:0] vel_z;

   modport source (
      output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
      output ready
   );
endinterface

interface arpv_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rot_pos_x;
   logic signed [COORD_WIDTH-1:0] rot_pos_y;
   logic signed [COORD_WIDTH-1:0] rot_pos_z;
   logic signed [COORD_WIDTH-1:0] rot_vel_x;
   logic signed [COORD_WIDTH-1:0] rot_vel_y;
   logic signed [COORD_WIDTH-1:0] rot_vel_z;

   modport source (
      output valid, rot_pos_x, rot_pos_y, rot_pos_z, rot_vel_x, rot_vel_y, rot_vel_z,
      input  ready
   );
   modport sink (
      input  valid, rot_pos_x, rot_pos_y, rot_pos_z, rot_vel_x, rot_vel_y, rot_vel_z,
      output ready
   );
endinterface

[rtl/arpv_rot_stage.sv]
// One plane rotation applied to position and velocity: a product stage and a
// combine/floor/saturate stage, each with its own valid bit. Uses arpv_pkg.
`include "axis_rotation_pos_vel_macros.svh"

module arpv_rot_stage #(
   parameter int                 COORD_WIDTH    = 32,
   parameter int                 COEF_FRAC_BITS = 16,
   parameter arpv_pkg::axis_type AXIS           = arpv_pkg::AXIS_X
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [COEF_FRAC_BITS+1:0] cos_val,
   input  logic signed [COEF_FRAC_BITS+1:0] sin_val,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [COORD_WIDTH-1:0]   in_vec [arpv_pkg::NUM_LANES],
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [COORD_WIDTH-1:0]   out_vec [arpv_pkg::NUM_LANES]
);
   import arpv_pkg::*;

   localparam int   COEF_W  = COEF_FRAC_BITS + 2;
   localparam int   PW      = COORD_WIDTH + COEF_W;     // exact product
   localparam int   SW      = PW + 1;                   // exact sum of two products
   localparam int   TW      = SW - COEF_FRAC_BITS;      // after the floor shift
   localparam int   LP      = axis_p_lane(AXIS);
   localparam int   LQ      = axis_q_lane(AXIS);
   localparam logic NEG_SIN = axis_neg_sin(AXIS);
   localparam int   GROUPS  = NUM_LANES / LANES_PER_GROUP;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [TW-1:0] v
   );
      logic signed [COORD_WIDTH-1:0] r;
      // in range when every bit above the coordinate's sign bit matches it
      if (v[TW-1:COORD_WIDTH-1] == {(TW-COORD_WIDTH+1){v[TW-1]}}) begin
         r = v[COORD_WIDTH-1:0];
      end else if (v[TW-1]) begin
         r = COORD_MIN;
      end else begin
         r = COORD_MAX;
      end
      return r;
   endfunction

   // ---------------- product stage ----------------
   logic                          m_vld_ff, m_vld_in, m_ready, m_load;
   logic signed [COORD_WIDTH-1:0] m_vec_ff [NUM_LANES];
   logic signed [PW-1:0]          m_cp_ff [GROUPS], m_cp_in [GROUPS];
   logic signed [PW-1:0]          m_sq_ff [GROUPS], m_sq_in [GROUPS];
   logic signed [PW-1:0]          m_cq_ff [GROUPS], m_cq_in [GROUPS];
   logic signed [PW-1:0]          m_sp_ff [GROUPS], m_sp_in [GROUPS];

   // ---------------- combine stage ----------------
   logic                          s_vld_ff, s_vld_in, s_ready, s_load;
   logic signed [COORD_WIDTH-1:0] s_vec_ff [NUM_LANES], s_vec_in [NUM_LANES];

   assign s_ready  = !s_vld_ff || out_ready;
   assign m_ready  = !m_vld_ff || s_ready;
   assign in_ready = m_ready;
   assign m_load   = m_ready && in_valid;
   assign m_vld_in = m_ready ? in_valid : m_vld_ff;
   assign s_load   = s_ready && m_vld_ff;
   assign s_vld_in = s_ready ? m_vld_ff : s_vld_ff;

   always_comb begin
      logic signed [PW-1:0] c_ext, s_ext, p_ext, q_ext;
      c_ext = PW'(cos_val);
      s_ext = PW'(sin_val);
      for (int g = 0; g < GROUPS; g++) begin
         p_ext      = PW'(in_vec[LANE_BITS'(LP + LANES_PER_GROUP * g)]);
         q_ext      = PW'(in_vec[LANE_BITS'(LQ + LANES_PER_GROUP * g)]);
         m_cp_in[g] = c_ext * p_ext;
         m_sq_in[g] = s_ext * q_ext;
         m_cq_in[g] = c_ext * q_ext;
         m_sp_in[g] = s_ext * p_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= m_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_load) begin
         m_vec_ff <= in_vec;
         m_cp_ff  <= m_cp_in;
         m_sq_ff  <= m_sq_in;
         m_cq_ff  <= m_cq_in;
         m_sp_ff  <= m_sp_in;
      end
   end

   // p' = c*p + s*q, q' = c*q - s*p, sine sign flipped for the y axis
   always_comb begin
      logic signed [SW-1:0] np_sum, nq_sum;
      s_vec_in = m_vec_ff;
      for (int g = 0; g < GROUPS; g++) begin
         if (NEG_SIN) begin
            np_sum = SW'(m_cp_ff[g]) - SW'(m_sq_ff[g]);
            nq_sum = SW'(m_cq_ff[g]) + SW'(m_sp_ff[g]);
         end else begin
            np_sum = SW'(m_cp_ff[g]) + SW'(m_sq_ff[g]);
            nq_sum = SW'(m_cq_ff[g]) - SW'(m_sp_ff[g]);
         end
         // dropping the fraction bits of a two's complement value floors it
         s_vec_in[LANE_BITS'(LP + LANES_PER_GROUP * g)] =
            sat_coord($signed(np_sum[SW-1:COEF_FRAC_BITS]));
         s_vec_in[LANE_BITS'(LQ + LANES_PER_GROUP * g)] =
            sat_coord($signed(nq_sum[SW-1:COEF_FRAC_BITS]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else begin
         s_vld_ff <= s_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s_load) begin
         s_vec_ff <= s_vec_in;
      end
   end

   assign out_valid = s_vld_ff;
   assign out_vec   = s_vec_ff;

   `ARPV_ASSERT_NEXT(a_beat_enters_products, in_valid && in_ready, m_vld_ff, "accepted beat not held in product stage")
   `ARPV_ASSERT_NEXT(a_blocked_product_kept, m_vld_ff && !s_ready, m_vld_ff, "product stage dropped a blocked beat")
   `ARPV_ASSERT_SAME(a_full_pipe_blocks_in, m_vld_ff && s_vld_ff && !out_ready, !in_ready, "input taken while both stages are blocked")
   `ARPV_ASSERT_NEXT(a_combine_fills, m_vld_ff && s_ready, s_vld_ff, "product beat lost on the way to combine stage")

endmodule

[rtl/axis_rotation_pos_vel.sv]
// Top level of the three-axis position/velocity rotator: coefficient registers
// and three arpv_rot_stage instances. Uses arpv_pkg and the arpv stream interfaces.
//
// Usage
//   req_bus carries one body per beat (pos_x/y/z, vel_x/y/z, signed, COEF_FRAC_BITS
//   fraction bits); rsp_bus returns the rotated six coordinates, one beat per input
//   beat, in order. The body is rotated about x, then y, then z; each new coordinate
//   is floor((c*a +/- s*b) / 2^COEF_FRAC_BITS), clamped to the coordinate range.
//   csr_we/csr_index/csr_wdata write the six cos/sin coefficients (cos x, sin x,
//   cos y, sin y, cos z, sin z); other indexes are ignored. Change them only while
//   no beat is in flight.
//   Two register stages per axis: products, then combine/floor/saturate.
//   Throughput: one beat per cycle while rsp_bus.ready is held high.
//   Stalls: each stage has its own valid bit and loads only when the next one is
//   free, so a stalled rsp_bus backs up stage by stage; req_bus.ready stays high
//   while any bubble is left. Nothing is dropped or repeated.
//   Reset: empties the pipeline and sets every rotation to identity (cos one, sin 0).
module axis_rotation_pos_vel #(
   parameter int COORD_WIDTH    = 32,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   arpv_req_if.sink                             req_bus,
   arpv_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [arpv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_FRAC_BITS+1:0]            csr_wdata
);
   import arpv_pkg::*;

   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

   logic signed [COEF_W-1:0] coef_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[CSR_COS_X] <= COEF_ONE;
         coef_ff[CSR_SIN_X] <= '0;
         coef_ff[CSR_COS_Y] <= COEF_ONE;
         coef_ff[CSR_SIN_Y] <= '0;
         coef_ff[CSR_COS_Z] <= COEF_ONE;
         coef_ff[CSR_SIN_Z] <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COS_X: coef_ff[CSR_COS_X] <= $signed(csr_wdata);
            CSR_SIN_X: coef_ff[CSR_SIN_X] <= $signed(csr_wdata);
            CSR_COS_Y: coef_ff[CSR_COS_Y] <= $signed(csr_wdata);
            CSR_SIN_Y: coef_ff[CSR_SIN_Y] <= $signed(csr_wdata);
            CSR_COS_Z: coef_ff[CSR_COS_Z] <= $signed(csr_wdata);
            CSR_SIN_Z: coef_ff[CSR_SIN_Z] <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   logic signed [COORD_WIDTH-1:0] in_vec [NUM_LANES];
   logic signed [COORD_WIDTH-1:0] x_vec  [NUM_LANES];
   logic signed [COORD_WIDTH-1:0] y_vec  [NUM_LANES];
   logic signed [COORD_WIDTH-1:0] z_vec  [NUM_LANES];
   logic x_valid, x_ready, y_valid, y_ready;

   always_comb begin
      in_vec[LANE_X]                   = req_bus.pos_x;
      in_vec[LANE_Y]                   = req_bus.pos_y;
      in_vec[LANE_Z]                   = req_bus.pos_z;
      in_vec[LANES_PER_GROUP + LANE_X] = req_bus.vel_x;
      in_vec[LANES_PER_GROUP + LANE_Y] = req_bus.vel_y;
      in_vec[LANES_PER_GROUP + LANE_Z] = req_bus.vel_z;
   end

   arpv_rot_stage #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .AXIS           (AXIS_X)
   ) u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .cos_val   (coef_ff[CSR_COS_X]),
      .sin_val   (coef_ff[CSR_SIN_X]),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_vec    (in_vec),
      .out_valid (x_valid),
      .out_ready (x_ready),
      .out_vec   (x_vec)
   );

   arpv_rot_stage #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .AXIS           (AXIS_Y)
   ) u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .cos_val   (coef_ff[CSR_COS_Y]),
      .sin_val   (coef_ff[CSR_SIN_Y]),
      .in_valid  (x_valid),
      .in_ready  (x_ready),
      .in_vec    (x_vec),
      .out_valid (y_valid),
      .out_ready (y_ready),
      .out_vec   (y_vec)
   );

   arpv_rot_stage #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .AXIS           (AXIS_Z)
   ) u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .cos_val   (coef_ff[CSR_COS_Z]),
      .sin_val   (coef_ff[CSR_SIN_Z]),
      .in_valid  (y_valid),
      .in_ready  (y_ready),
      .in_vec    (y_vec),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_vec   (z_vec)
   );

   assign rsp_bus.rot_pos_x = z_vec[LANE_X];
   assign rsp_bus.rot_pos_y = z_vec[LANE_Y];
   assign rsp_bus.rot_pos_z = z_vec[LANE_Z];
   assign rsp_bus.rot_vel_x = z_vec[LANES_PER_GROUP + LANE_X];
   assign rsp_bus.rot_vel_y = z_vec[LANES_PER_GROUP + LANE_Y];
   assign rsp_bus.rot_vel_z = z_vec[LANES_PER_GROUP + LANE_Z];

endmodule

[tb/axis_rotation_pos_vel_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for axis_rotation_pos_vel: x/y/z rotation of position and velocity.
// Needs arpv_pkg, the arpv stream interfaces and the RTL; each beat is scored against a
// typed-in expectation or a bit-exact rotation predictor.
module axis_rotation_pos_vel_tb;
   import arpv_pkg::*;

   localparam int COORD_W    = 32;
   localparam int COEF_FRAC  = 16;
   localparam int COEF_W     = COEF_FRAC + 2;
   localparam int PHASES     = 16;
   localparam int PHASE_BEATS = 100;
   localparam int HOLD_CYCLES = 300;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic signed [COORD_W-1:0] MAXC  = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] MINC  = 32'sh80000000;
   localparam logic signed [COORD_W-1:0] NMAXC = -32'sd2147483647;
   localparam logic signed [COORD_W-1:0] A5    = 32'sh55555555;
   localparam logic signed [COORD_W-1:0] AA    = 32'shaaaaaaaa;
   localparam logic signed [COORD_W-1:0] P1    = 32'sd1;
   localparam logic signed [COORD_W-1:0] M1    = -32'sd1;
   localparam logic signed [COORD_W-1:0] ONE_Q = 32'sd65536;

   localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd65536;
   localparam logic signed [COEF_W-1:0] COEF_NEG  = -18'sd65536;
   localparam logic signed [COEF_W-1:0] COEF_HALF = 18'sd32768;
   localparam logic signed [COEF_W-1:0] COEF_TOP  = 18'sd131071;
   localparam logic signed [COEF_W-1:0] COEF_BOT  = 18'sh20000;
   localparam logic signed [COEF_W-1:0] COEF_NIL  = 18'sd0;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] vel_x;
      logic signed [COORD_W-1:0] vel_y;
      logic signed [COORD_W-1:0] vel_z;
   } body_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] rot_pos_x;
      logic signed [COORD_W-1:0] rot_pos_y;
      logic signed [COORD_W-1:0] rot_pos_z;
      logic signed [COORD_W-1:0] rot_vel_x;
      logic signed [COORD_W-1:0] rot_vel_y;
      logic signed [COORD_W-1:0] rot_vel_z;
   } rot_type;

   typedef struct {
      int       coef_sel;
      body_type body;
      bit       has_exp;
      rot_type  exp;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [COEF_W-1:0]          csr_wdata;

   arpv_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   arpv_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_bus ();

   axis_rotation_pos_vel #(
      .COORD_WIDTH   (COORD_W),
      .COEF_FRAC_BITS(COEF_FRAC)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   csr_index_type reg_order [6] = '{CSR_COS_X, CSR_SIN_X, CSR_COS_Y,
                                    CSR_SIN_Y, CSR_COS_Z, CSR_SIN_Z};
   logic signed [COEF_W-1:0] rot_coef  [6];
   logic signed [COEF_W-1:0] next_coef [6];
   logic signed [COEF_W-1:0] coef_set  [8][6];

   dir_row_type dir_rows [$];
   rot_type     rotated_q [$];

   // typed-in expectation travels with the beat on the bus
   bit      body_has_exp;
   rot_type body_exp;

   bit idle_en;
   bit hold_req;
   int fail_count;
   int bodies_accepted;
   int beats_checked;
   int coef_loads;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // floor((c*a + s*b) / 2^F), clamped to the coordinate range
   function automatic longint fix_mac(longint c, longint a, longint s, longint b);
      longint acc;
      acc = (c * a + s * b) >>> COEF_FRAC;
      if (acc > longint'(MAXC)) acc = longint'(MAXC);
      if (acc < longint'(MINC)) acc = longint'(MINC);
      return acc;
   endfunction

   function automatic void rotate_plane(input longint c, input longint s,
                                        inout longint p, inout longint q);
      longint np, nq;
      np = fix_mac(c, p, s, q);
      nq = fix_mac(c, q, -s, p);
      p = np;
      q = nq;
   endfunction

   function automatic rot_type rotate_body(body_type b);
      longint v [6];
      longint cx, sx, cy, sy, cz, sz;
      rot_type r;
      cx = longint'(rot_coef[CSR_COS_X]);
      sx = longint'(rot_coef[CSR_SIN_X]);
      cy = longint'(rot_coef[CSR_COS_Y]);
      sy = longint'(rot_coef[CSR_SIN_Y]);
      cz = longint'(rot_coef[CSR_COS_Z]);
      sz = longint'(rot_coef[CSR_SIN_Z]);
      v[0] = longint'(b.pos_x);
      v[1] = longint'(b.pos_y);
      v[2] = longint'(b.pos_z);
      v[3] = longint'(b.vel_x);
      v[4] = longint'(b.vel_y);
      v[5] = longint'(b.vel_z);
      rotate_plane(cx, sx, v[1], v[2]);
      rotate_plane(cx, sx, v[4], v[5]);
      // y plane is (x, z) with the sine flipped
      rotate_plane(cy, -sy, v[0], v[2]);
      rotate_plane(cy, -sy, v[3], v[5]);
      rotate_plane(cz, sz, v[0], v[1]);
      rotate_plane(cz, sz, v[3], v[4]);
      r.rot_pos_x = v[0][COORD_W-1:0];
      r.rot_pos_y = v[1][COORD_W-1:0];
      r.rot_pos_z = v[2][COORD_W-1:0];
      r.rot_vel_x = v[3][COORD_W-1:0];
      r.rot_vel_y = v[4][COORD_W-1:0];
      r.rot_vel_z = v[5][COORD_W-1:0];
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord(bit noisy);
      int unsigned pick;
      logic signed [COORD_W-1:0] v;
      pick = $urandom_range(0, 9);
      if (!noisy)
         v = $signed($urandom) >>> $urandom_range(4, 16);
      else if (pick == 0)
         v = MAXC;
      else if (pick == 1)
         v = MINC;
      else if (pick == 2)
         v = '0;
      else
         v = $urandom;
      return v;
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_coef();
      logic signed [COEF_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = COEF_ONE;
         1:       v = COEF_NEG;
         2:       v = COEF_NIL;
         3:       v = COEF_TOP;
         4:       v = COEF_BOT;
         5, 6:    v = COEF_W'($urandom_range(0, 131072) - 65536);
         default: v = COEF_W'($urandom);
      endcase
      return v;
   endfunction

   task automatic check_field(string name, logic signed [COORD_W-1:0] want,
                              logic signed [COORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic add_row(int coef_sel, body_type b, bit has_exp, rot_type e);
      dir_row_type r;
      r.coef_sel = coef_sel;
      r.body     = b;
      r.has_exp  = has_exp;
      r.exp      = e;
      dir_rows.push_back(r);
   endtask

   task automatic load_coefs();
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_order[i];
         csr_wdata <= next_coef[i];
         @(posedge clock);
         rot_coef[reg_order[i]] = next_coef[i];
      end
      // stray write to an unmapped index must leave all six alone
      csr_index <= $urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7;
      csr_wdata <= COEF_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      coef_loads++;
   endtask

   // drops valid and waits for a clock edge first so a beat accepted at the current edge is already queued
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_body(body_type b, bit has_exp, rot_type e);
      int unsigned gap;
      gap = idle_en ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pos_x <= b.pos_x;
      req_bus.pos_y <= b.pos_y;
      req_bus.pos_z <= b.pos_z;
      req_bus.vel_x <= b.vel_x;
      req_bus.vel_y <= b.vel_y;
      req_bus.vel_z <= b.vel_z;
      body_has_exp  <= has_exp;
      body_exp      <= e;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // scoreboard: queue on input accept, compare on output accept
   always @(posedge clock) begin : scoreboard
      body_type b;
      rot_type  want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            b = {req_bus.pos_x, req_bus.pos_y, req_bus.pos_z,
                 req_bus.vel_x, req_bus.vel_y, req_bus.vel_z};
            rotated_q.push_back(body_has_exp ? body_exp : rotate_body(b));
            bodies_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rotated_q.size() == 0) begin
               $error("rotated beat with no body outstanding");
               fail_count++;
            end else begin
               want = rotated_q.pop_front();
               check_field("rot_pos_x", want.rot_pos_x, rsp_bus.rot_pos_x);
               check_field("rot_pos_y", want.rot_pos_y, rsp_bus.rot_pos_y);
               check_field("rot_pos_z", want.rot_pos_z, rsp_bus.rot_pos_z);
               check_field("rot_vel_x", want.rot_vel_x, rsp_bus.rot_vel_x);
               check_field("rot_vel_y", want.rot_vel_y, rsp_bus.rot_vel_y);
               check_field("rot_vel_z", want.rot_vel_z, rsp_bus.rot_vel_z);
               beats_checked++;
            end
         end
      end
   end

   initial begin : rsp_sink
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            stall = idle_en ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAIL axis_rotation_pos_vel");
      $finish;
   end

   initial begin : stimulus
      int       cur_sel;
      real      ang;
      bit       noisy;
      body_type b;

      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      req_bus.pos_z <= '0;
      req_bus.vel_x <= '0;
      req_bus.vel_y <= '0;
      req_bus.vel_z <= '0;
      body_has_exp  <= 1'b0;
      body_exp      <= '0;
      idle_en  = 1'b1;
      hold_req = 1'b0;

      rot_coef[CSR_COS_X] = COEF_ONE;
      rot_coef[CSR_SIN_X] = COEF_NIL;
      rot_coef[CSR_COS_Y] = COEF_ONE;
      rot_coef[CSR_SIN_Y] = COEF_NIL;
      rot_coef[CSR_COS_Z] = COEF_ONE;
      rot_coef[CSR_SIN_Z] = COEF_NIL;

      coef_set[0] = '{COEF_ONE, COEF_NIL, COEF_ONE, COEF_NIL, COEF_ONE, COEF_NIL};
      coef_set[1] = '{COEF_NEG, COEF_NIL, COEF_ONE, COEF_NIL, COEF_ONE, COEF_NIL};
      coef_set[2] = '{COEF_ONE, COEF_NIL, COEF_ONE, COEF_NIL, COEF_NIL, COEF_ONE};
      coef_set[3] = '{COEF_TOP, COEF_BOT, COEF_TOP, COEF_BOT, COEF_TOP, COEF_BOT};
      coef_set[4] = '{COEF_BOT, COEF_TOP, COEF_BOT, COEF_TOP, COEF_BOT, COEF_TOP};
      coef_set[5] = '{COEF_NIL, COEF_NIL, COEF_NIL, COEF_NIL, COEF_NIL, COEF_NIL};
      coef_set[6] = '{COEF_HALF, COEF_NIL, COEF_ONE, COEF_NIL, COEF_ONE, COEF_NIL};
      coef_set[7] = '{COEF_ONE, COEF_NIL, COEF_NIL, COEF_ONE, COEF_ONE, COEF_NIL};

      // identity straight out of reset
      add_row(0, {6{32'sd0}}, 1, {6{32'sd0}});
      add_row(0, {6{MAXC}}, 1, {6{MAXC}});
      add_row(0, {6{MINC}}, 1, {6{MINC}});
      add_row(0, {A5, A5, A5, AA, AA, AA}, 1, {A5, A5, A5, AA, AA, AA});
      add_row(0, {P1, M1, P1, M1, P1, M1}, 1, {P1, M1, P1, M1, P1, M1});
      // all coefficients zero
      add_row(5, {6{MAXC}}, 1, {6{32'sd0}});
      add_row(5, {6{MINC}}, 1, {6{32'sd0}});
      // half turn about x: y and z flip, negating the minimum saturates
      add_row(1, {ONE_Q, 32'sd131072, 32'sd196608, 32'sd5, MINC, MAXC}, 1,
              {ONE_Q, -32'sd131072, -32'sd196608, 32'sd5, MAXC, NMAXC});
      add_row(1, {A5, AA, A5, AA, A5, AA}, 0, '0);
      // quarter turn about z: (x, y) -> (y, -x)
      add_row(2, {MINC, 32'sd7, 32'sd9, 32'sd3, -32'sd4, MAXC}, 1,
              {32'sd7, MAXC, 32'sd9, -32'sd4, -32'sd3, MAXC});
      // quarter turn about y: (x, z) -> (-z, x), checks the sine sign
      add_row(7, {P1, 32'sd2, 32'sd3, MINC, 32'sd5, MAXC}, 1,
              {-32'sd3, 32'sd2, P1, NMAXC, 32'sd5, MINC});
      // cos one half: floor rounding toward minus infinity
      add_row(6, {32'sd0, M1, 32'sd3, 32'sd0, P1, -32'sd3}, 1,
              {32'sd0, M1, P1, 32'sd0, 32'sd0, -32'sd2});
      // coefficient extremes beyond one, heavy saturation
      for (int s = 3; s <= 4; s++) begin
         add_row(s, {6{MAXC}}, 0, '0);
         add_row(s, {6{MINC}}, 0, '0);
         add_row(s, {A5, AA, A5, AA, A5, AA}, 0, '0);
         add_row(s, {P1, M1, MAXC, MINC, 32'sd0, ONE_Q}, 0, '0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      cur_sel = 0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].coef_sel != cur_sel) begin
            drain();
            cur_sel = dir_rows[i].coef_sel;
            for (int k = 0; k < 6; k++) next_coef[k] = coef_set[cur_sel][k];
            load_coefs();
         end
         send_body(dir_rows[i].body, dir_rows[i].has_exp, dir_rows[i].exp);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p % 3)
            0: begin
               for (int k = 0; k < 3; k++) begin
                  ang = $urandom_range(0, 62831) / 10000.0;
                  next_coef[2*k]   = COEF_W'($rtoi(65536.0 * $cos(ang)));
                  next_coef[2*k+1] = COEF_W'($rtoi(65536.0 * $sin(ang)));
               end
            end
            1: for (int k = 0; k < 6; k++) next_coef[k] = rand_coef();
            default: begin
               for (int k = 0; k < 6; k++) begin
                  case ($urandom_range(0, 4))
                     0:       next_coef[k] = COEF_ONE;
                     1:       next_coef[k] = COEF_NEG;
                     2:       next_coef[k] = COEF_NIL;
                     3:       next_coef[k] = COEF_TOP;
                     default: next_coef[k] = COEF_BOT;
                  endcase
               end
            end
         endcase
         load_coefs();
         idle_en = (p % 4 != 1);
         // back-to-back beats into a blocked output so the pipe fills
         if (p == 5) begin
            idle_en  = 1'b0;
            hold_req = 1'b1;
         end
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if (p == 7 && k == PHASE_BEATS / 2) drain();
            noisy = ($urandom_range(0, 4) == 0);
            b.pos_x = rand_coord(noisy);
            b.pos_y = rand_coord(noisy);
            b.pos_z = rand_coord(noisy);
            b.vel_x = rand_coord(noisy);
            b.vel_y = rand_coord(noisy);
            b.vel_z = rand_coord(noisy);
            send_body(b, 1'b0, '0);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (rotated_q.size() != 0) begin
         $error("%0d rotated beats never arrived", rotated_q.size());
         fail_count++;
      end
      $display("Rotated %0d bodies under %0d coefficient loads; %0d output beats compared.",
               bodies_accepted, coef_loads, beats_checked);
      if (fail_count == 0)
         $display("PASS axis_rotation_pos_vel");
      else
         $display("FAIL axis_rotation_pos_vel");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/arpv_pkg.sv
rtl/arpv_stream_if.sv
rtl/arpv_rot_stage.sv
rtl/axis_rotation_pos_vel.sv
tb/axis_rotation_pos_vel_tb.sv
